FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define TDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, ignored while reset is high
`define TDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also holds across reset
`define TDC_ASSERT_NEXT_NORST(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

FILE: hdl/tdc_pkg.sv
// types, constants and helper functions of the touch dimmer controller
`default_nettype none
package tdc_pkg;

   // touch readings summed into one tick
   localparam int SAMPLES_PER_TICK = 4;

   // default depth of the internal queues
   localparam int TDC_QUEUE_DEPTH = 2;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOUCH_THRESHOLD    = 3'd0,
      CSR_RELEASE_HYSTERESIS = 3'd1,
      CSR_CONFIRM_COUNT      = 3'd2,
      CSR_ANIM_INTERVAL_MS   = 3'd3,
      CSR_MIN_BRIGHTNESS     = 3'd4,
      CSR_LONG_TOUCH_MS      = 3'd5
   } tdc_csr_type;

   // register reset values
   localparam logic [15:0] RST_TOUCH_THRESHOLD    = 16'd40;
   localparam logic [15:0] RST_RELEASE_HYSTERESIS = 16'd5;
   localparam logic [3:0]  RST_CONFIRM_COUNT      = 4'd3;
   localparam logic [15:0] RST_ANIM_INTERVAL_MS   = 16'd10;
   localparam logic [7:0]  RST_MIN_BRIGHTNESS     = 8'd10;
   localparam logic [15:0] RST_LONG_TOUCH_MS      = 16'd1000;

   // hue scaling: pot * HUE_MAX / POT_MAX = 16 * pot + pot / HUE_FRAC_DIV
   localparam int POT_MAX      = 4095;
   localparam int HUE_MAX      = 65535;
   localparam int HUE_FRAC_MAX = HUE_MAX % POT_MAX;
   localparam int HUE_FRAC_DIV = POT_MAX / HUE_FRAC_MAX;

   // top of the brightness ramp
   localparam logic [9:0] BRIGHT_MAX = 10'd255;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_TOUCH = 2'd1,
      PHASE_LONG  = 2'd2
   } tdc_phase_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        received_mode;
      logic        lamp_on;
      logic [7:0]  lamp_brightness;
      logic [11:0] pot_raw;
      logic [17:0] touch_sum;
   } tdc_req_type;

   typedef struct packed {
      logic        hue_write;
      logic [15:0] hue;
      logic        power_write;
      logic        power_value;
      logic        brightness_write;
      logic [7:0]  brightness_value;
      logic        touch_is_active;
      logic [1:0]  touch_phase_out;
   } tdc_rsp_type;

   typedef struct packed {
      logic [15:0] touch_threshold;
      logic [15:0] release_hysteresis;
      logic [3:0]  confirm_count;
      logic [15:0] anim_interval_ms;
      logic [7:0]  min_brightness;
      logic [15:0] long_touch_ms;
   } tdc_cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [31:0] now_ms;
      logic        received_mode;
      logic        lamp_on;
      logic [7:0]  lamp_brightness;
      logic [15:0] hue;
      logic        below_idle;
      logic        below_active;
   } tdc_work_type;

   // pot to hue; the fraction term is a row of constant compares
   function automatic logic [15:0] tdc_hue(input logic [11:0] pot);
      logic [3:0] frac;
      frac = '0;
      for (int k = 1; k <= HUE_FRAC_MAX; k++) begin
         if (32'(pot) >= k * HUE_FRAC_DIV) begin
            frac = 4'(k);
         end
      end
      return {pot, 4'b0000} + {12'b0, frac};
   endfunction

endpackage
`default_nettype wire

FILE: hdl/tdc_queue.sv
// small register queue with push/full and pop/empty sides
`default_nettype none
module tdc_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/tdc_front.sv
// front stage: takes items, maps hue and classifies the touch average
`default_nettype none
module tdc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  tdc_pkg::tdc_req_type req_item,
   input  tdc_pkg::tdc_cfg_type cfg,
   output logic                 work_push,
   input  logic                 work_full,
   output tdc_pkg::tdc_work_type work_item
);
   import tdc_pkg::*;

   logic         stage_valid_ff, stage_valid_in;
   tdc_work_type stage_ff, stage_in;
   logic         accept;
   logic [15:0]  avg;
   logic [15:0]  release_level;

   assign full      = stage_valid_ff && work_full;
   assign accept    = push && !full;
   assign work_push = stage_valid_ff && !work_full;
   assign work_item = stage_ff;

   // touch average and both hysteresis compares
   assign avg           = 16'(req_item.touch_sum / SAMPLES_PER_TICK);
   assign release_level = cfg.touch_threshold + cfg.release_hysteresis;

   always_comb begin
      stage_in                 = stage_ff;
      stage_valid_in           = stage_valid_ff;
      if (work_push) begin
         stage_valid_in = 1'b0;
      end
      if (accept) begin
         stage_valid_in           = 1'b1;
         stage_in.now_ms          = req_item.now_ms;
         stage_in.received_mode   = req_item.received_mode;
         stage_in.lamp_on         = req_item.lamp_on;
         stage_in.lamp_brightness = req_item.lamp_brightness;
         stage_in.hue             = tdc_hue(req_item.pot_raw);
         stage_in.below_idle      = (avg < cfg.touch_threshold);
         stage_in.below_active    = (avg < release_level);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

endmodule
`default_nettype wire

FILE: hdl/tdc_back.sv
// back stage: touch qualification, phase machine and brightness ramp
`default_nettype none
module tdc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  tdc_pkg::tdc_cfg_type  cfg,
   input  logic                  work_empty,
   output logic                  work_pop,
   input  tdc_pkg::tdc_work_type work_item,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output tdc_pkg::tdc_rsp_type  rsp_item
);
   import tdc_pkg::*;

   logic          active_ff, active_in;
   logic [3:0]    below_cnt_ff, below_cnt_in;
   logic [3:0]    above_cnt_ff, above_cnt_in;
   tdc_phase_type phase_ff, phase_in;
   logic [31:0]   start_ff, start_in;
   logic [31:0]   last_step_ff, last_step_in;
   logic          ramp_down_ff, ramp_down_in;

   logic          below;
   logic [3:0]    below_cnt_mid, above_cnt_mid;
   logic          active_mid;
   tdc_phase_type phase_a, phase_b;
   logic [31:0]   start_a;
   logic          long_hit, step;
   logic [9:0]    next_level;
   logic [7:0]    step_level;
   logic          step_down;

   assign work_pop = !work_empty && !rsp_full;
   assign rsp_push = work_pop;

   // hysteresis compare and confirmation counters
   always_comb begin
      below = active_ff ? work_item.below_active : work_item.below_idle;
      if (below) begin
         above_cnt_mid = '0;
         below_cnt_mid = (below_cnt_ff < cfg.confirm_count) ? below_cnt_ff + 1'b1
                                                            : below_cnt_ff;
      end else begin
         below_cnt_mid = '0;
         above_cnt_mid = (above_cnt_ff < cfg.confirm_count) ? above_cnt_ff + 1'b1
                                                            : above_cnt_ff;
      end
      if (!active_ff && below_cnt_mid >= cfg.confirm_count) begin
         active_mid = 1'b1;
      end else if (active_ff && above_cnt_mid >= cfg.confirm_count) begin
         active_mid = 1'b0;
      end else begin
         active_mid = active_ff;
      end
   end

   // phase machine and ramp step
   always_comb begin
      case (phase_ff)
         PHASE_IDLE: begin
            phase_a = PHASE_TOUCH;
            start_a = work_item.now_ms;
         end
         PHASE_TOUCH, PHASE_LONG: begin
            phase_a = phase_ff;
            start_a = start_ff;
         end
         default: begin
            phase_a = phase_ff;
            start_a = start_ff;
         end
      endcase
      long_hit = (phase_a == PHASE_TOUCH) &&
                 ((work_item.now_ms - start_a) >= {16'b0, cfg.long_touch_ms});
      phase_b  = long_hit ? PHASE_LONG : phase_a;
      step     = (phase_b == PHASE_LONG) &&
                 ((work_item.now_ms - last_step_ff) > {16'b0, cfg.anim_interval_ms});

      // ramp one level, clamp at floor and top
      next_level = ramp_down_ff ? {2'b00, work_item.lamp_brightness} - 10'd1
                                : {2'b00, work_item.lamp_brightness} + 10'd1;
      if ($signed(next_level) <= $signed({2'b00, cfg.min_brightness})) begin
         step_level = cfg.min_brightness;
         step_down  = 1'b0;
      end else if ($signed(next_level) >= $signed(BRIGHT_MAX)) begin
         step_level = BRIGHT_MAX[7:0];
         step_down  = 1'b1;
      end else begin
         step_level = next_level[7:0];
         step_down  = ramp_down_ff;
      end

      // defaults: state holds, result carries the unchanged touch state
      active_in    = active_ff;
      below_cnt_in = below_cnt_ff;
      above_cnt_in = above_cnt_ff;
      phase_in     = phase_ff;
      start_in     = start_ff;
      last_step_in = last_step_ff;
      ramp_down_in = ramp_down_ff;
      rsp_item     = '0;

      if (work_pop && !work_item.received_mode) begin
         active_in    = active_mid;
         below_cnt_in = below_cnt_mid;
         above_cnt_in = above_cnt_mid;
         if (work_item.lamp_on) begin
            rsp_item.hue_write = 1'b1;
            rsp_item.hue       = work_item.hue;
         end
         if (active_mid) begin
            phase_in = phase_b;
            start_in = start_a;
            if (long_hit && !work_item.lamp_on) begin
               rsp_item.power_write = 1'b1;
               rsp_item.power_value = 1'b1;
            end
            if (step) begin
               last_step_in              = work_item.now_ms;
               ramp_down_in              = step_down;
               rsp_item.brightness_write = 1'b1;
               rsp_item.brightness_value = step_level;
            end
         end else begin
            if (phase_ff == PHASE_TOUCH) begin
               rsp_item.power_write = 1'b1;
               rsp_item.power_value = !work_item.lamp_on;
            end
            phase_in = PHASE_IDLE;
         end
      end

      rsp_item.touch_is_active = active_in;
      rsp_item.touch_phase_out = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         below_cnt_ff <= '0;
         above_cnt_ff <= '0;
         phase_ff     <= PHASE_IDLE;
         start_ff     <= '0;
         last_step_ff <= '0;
         ramp_down_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         below_cnt_ff <= below_cnt_in;
         above_cnt_ff <= above_cnt_in;
         phase_ff     <= phase_in;
         start_ff     <= start_in;
         last_step_ff <= last_step_in;
         ramp_down_ff <= ramp_down_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/touch_dimmer_controller.sv
// Touch dimmer controller: one tick item in, one result item out.
// Input side is a queue write port: an item is taken on a clock edge with
// push high and full low. Result side is a queue read port: the oldest
// result sits on rsp_item while empty is low and leaves on an edge with pop
// high. The csr_ port writes one of six registers on any edge with
// csr_write_en high; write only while no item is in flight.
// An item is registered in the front stage and written into the middle queue;
// the back stage then writes its result into the result queue.
// Throughput: one item per cycle while the result queue has room; the back
// stage finishes one tick per cycle: touch updates are compares and counters.
// When the receiver stalls, results collect in the result queue, then the
// middle queue and front register fill and full rises; nothing is dropped.
// Reset clears both queues, the touch state and the phase machine, and loads
// the register defaults. No memory clearing pass is needed.
`default_nettype none
module touch_dimmer_controller #(
   parameter int WORK_DEPTH = tdc_pkg::TDC_QUEUE_DEPTH,
   parameter int RSP_DEPTH  = tdc_pkg::TDC_QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  tdc_pkg::tdc_req_type             req_item,
   output logic                             empty,
   input  logic                             pop,
   output tdc_pkg::tdc_rsp_type             rsp_item,
   input  logic                             csr_write_en,
   input  logic [tdc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [tdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tdc_pkg::*;

   tdc_cfg_type  cfg_ff, cfg_in;
   logic         work_push, work_full, work_pop, work_empty;
   tdc_work_type front_work, back_work;
   logic         rsp_push, rsp_full;
   tdc_rsp_type  back_rsp;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (tdc_csr_type'(csr_index))
            CSR_TOUCH_THRESHOLD:    cfg_in.touch_threshold    = csr_wdata;
            CSR_RELEASE_HYSTERESIS: cfg_in.release_hysteresis = csr_wdata;
            CSR_CONFIRM_COUNT:      cfg_in.confirm_count      = csr_wdata[3:0];
            CSR_ANIM_INTERVAL_MS:   cfg_in.anim_interval_ms   = csr_wdata;
            CSR_MIN_BRIGHTNESS:     cfg_in.min_brightness     = csr_wdata[7:0];
            CSR_LONG_TOUCH_MS:      cfg_in.long_touch_ms      = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_threshold    <= RST_TOUCH_THRESHOLD;
         cfg_ff.release_hysteresis <= RST_RELEASE_HYSTERESIS;
         cfg_ff.confirm_count      <= RST_CONFIRM_COUNT;
         cfg_ff.anim_interval_ms   <= RST_ANIM_INTERVAL_MS;
         cfg_ff.min_brightness     <= RST_MIN_BRIGHTNESS;
         cfg_ff.long_touch_ms      <= RST_LONG_TOUCH_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: take and classify items
   tdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cfg       (cfg_ff),
      .work_push (work_push),
      .work_full (work_full),
      .work_item (front_work)
   );

   // queue between front and back
   tdc_queue #(
      .WIDTH ($bits(tdc_work_type)),
      .DEPTH (WORK_DEPTH)
   ) u_work_queue (
      .clock (clock),
      .reset (reset),
      .push  (work_push),
      .full  (work_full),
      .wdata (front_work),
      .pop   (work_pop),
      .empty (work_empty),
      .rdata (back_work)
   );

   // back: touch state and lamp commands
   tdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_empty (work_empty),
      .work_pop   (work_pop),
      .work_item  (back_work),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_item   (back_rsp)
   );

   // result queue
   tdc_queue #(
      .WIDTH ($bits(tdc_rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (back_rsp),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_item)
   );

endmodule
`default_nettype wire

FILE: hdl/tdc_checker.sv
// port-level checks for the touch dimmer controller, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module tdc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 full,
   input logic                 empty,
   input logic                 pop,
   input tdc_pkg::tdc_rsp_type rsp_item
);
   import tdc_pkg::*;

   // reset leaves both sides free
   `TDC_ASSERT_NEXT_NORST(a_reset_clears, clock, reset, empty && !full)

   // qualified touch and phase agree on every result
   `TDC_ASSERT_IMPL(a_phase_matches_touch, clock, reset, !empty, rsp_item.touch_is_active == (rsp_item.touch_phase_out != PHASE_IDLE))

   // value fields are zero when their write flag is clear
   `TDC_ASSERT_IMPL(a_flags_gate_values, clock, reset, !empty, (rsp_item.hue_write || rsp_item.hue == '0) && (rsp_item.power_write || !rsp_item.power_value) && (rsp_item.brightness_write || rsp_item.brightness_value == '0))

   // a waiting result holds while not taken
   `TDC_ASSERT_NEXT(a_result_holds, clock, reset, !empty && !pop, !empty && $stable(rsp_item))

endmodule

bind touch_dimmer_controller tdc_checker u_tdc_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
`default_nettype wire
